[rtl/fpsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_pkg: shared types and constants of the five-point stencil averager
// Register indexes, job flags and the divide-by-five digit step.
// ----------------------------------------------------------------------------
package fpsa_pkg;

  localparam int SampleFieldW = 32;   // width of the stream data fields
  localparam int CfgDataW     = 11;   // width of a configuration register
  localparam int RowW         = 10;   // row counter width
  localparam int HeightLimit  = 1024; // largest usable grid height
  localparam int DimReset     = 1024; // reset value of the height register, and of the width up to MAX_WIDTH
  localparam int MinDim       = 3;    // smallest usable dimension
  localparam int QueueDepth   = 4;    // entries between front and back

  // Divide by five one byte at a time: x / 5 == (x * 3277) >> 14 for x < 1280
  localparam int DivDigitW    = 8;
  localparam int DivXW        = DivDigitW + 3;
  localparam int DivProdW     = DivXW + 12;
  localparam int DivRecip     = 3277;
  localparam int DivShift     = 14;
  localparam int DivDivisor   = 5;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } fpsa_reg_e;

  typedef struct packed {
    logic border; // first result passes the centre cell through
    logic two;    // last row: the sample itself follows as a second result
    logic fend;   // second result closes the frame
  } fpsa_flags_t;

  typedef struct packed {
    logic [DivDigitW-1:0] q;
    logic [2:0]           r;
  } fpsa_digit_t;

  function automatic fpsa_digit_t div5_digit(input logic [DivXW-1:0] x);
    logic [DivProdW-1:0] p;
    logic [DivXW-1:0]    m5;
    fpsa_digit_t         d;
    p   = DivProdW'(x) * DivProdW'(DivRecip);
    d.q = p[DivShift +: DivDigitW];
    m5  = DivXW'(d.q) * DivXW'(DivDivisor);
    d.r = 3'(x - m5);
    return d;
  endfunction

endpackage

[rtl/five_point_stencil_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_point_stencil_average: one Jacobi sweep of a 2-D heat grid
// Samples stream in raster order; each sample from row one on releases the
// updated value of the cell one row above it.
// ----------------------------------------------------------------------------
// Use:
//   s_axis carries one grid sample per request, raster order, row 0 first.
//   m_axis returns updated cells: interior cells are the rounded mean of the
//   cell and its four neighbours, border cells pass through (tuser = 1).
//   Row 0 gives no result; during the last row every sample gives two
//   results, the cell above and then the sample itself as a border cell;
//   tlast marks the final cell of the frame.
//   cfg writes grid_width (index 0) and grid_height (index 1), clamped to
//   3..MAX_WIDTH and 3..1024; write them only while the block is idle.
// Timing:
//   One sample per cycle while the job queue has room; the last row is bound
//   by the output at two results per sample. A result passes the job queue,
//   the sum stage, one divider stage per byte of the five-point sum and the
//   output register.
// Reset clears counters, queue and valid flags; dimensions return to 1024,
// the width to MAX_WIDTH if that is smaller. When m_axis stalls, the back
// pipeline holds, the four-entry job queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module five_point_stencil_average
  import fpsa_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // sample stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [SampleFieldW-1:0] s_axis_tdata,   // [31:0] sample
  // result stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [SampleFieldW-1:0] m_axis_tdata,   // [31:0] new_value
  output logic                    m_axis_tuser,   // [0] is_border
  output logic                    m_axis_tlast,   // frame_end
  // configuration writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i
);

  // only the low bits of a sample take part, never more than the field holds
  localparam int DW = (SAMPLE_BITS < SampleFieldW) ? SAMPLE_BITS : SampleFieldW;
  localparam int JW = $bits(fpsa_flags_t) + 2 * (DW + 1) + 2 * DW;

  logic              job_valid, job_ready;
  fpsa_flags_t       job_flags, q_flags;
  logic [DW:0]       job_pair0, job_pair1, q_pair0, q_pair1;
  logic [DW-1:0]     job_mid, job_s, q_mid, q_s;
  logic [JW-1:0]     job_data, q_data;
  logic              q_valid, q_ready;
  logic [DW-1:0]     res_value;

  // front: position tracking, line store, job build
  fpsa_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .DATA_W    (DW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata[DW-1:0]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_flags_o (job_flags),
    .job_pair0_o (job_pair0),
    .job_pair1_o (job_pair1),
    .job_mid_o   (job_mid),
    .job_s_o     (job_s)
  );

  assign job_data = {job_flags, job_pair0, job_pair1, job_mid, job_s};

  // decoupling queue: the front takes samples during output stalls until full
  fpsa_queue #(
    .WIDTH (JW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign {q_flags, q_pair0, q_pair1, q_mid, q_s} = q_data;

  // back: sum, divide by five, results out
  fpsa_back #(
    .DATA_W (DW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_ready_o  (q_ready),
    .job_flags_i  (q_flags),
    .job_pair0_i  (q_pair0),
    .job_pair1_i  (q_pair1),
    .job_mid_i    (q_mid),
    .job_s_i      (q_s),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (res_value),
    .out_border_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = SampleFieldW'(res_value);

  // the front only produces a job when the queue can hold it
  a_job_never_dropped : assert property (
    @(posedge clk_i) disable iff (!rst_ni) job_valid |-> job_ready
  ) else $error("job pushed into a full queue");

  // the frame always closes on a border cell of the last row
  a_frame_end_on_border : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser
  ) else $error("frame end flagged on an interior cell");

  // a stalled result holds still until the receiver takes it
  a_result_held_while_stalled : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast))
  ) else $error("result changed while stalled");

endmodule

[rtl/fpsa_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_queue: short job queue between front and back
// Register-based FIFO; ready is a registered count compare.
// ----------------------------------------------------------------------------
module fpsa_queue
  import fpsa_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != NW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = store_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + NW'(1);
    end else if (pop && !push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/fpsa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_front: sample intake, line store and cell classification
// Tracks the raster position, keeps the two previous rows and builds one job
// per sample from row one onwards.
// ----------------------------------------------------------------------------
module fpsa_front
  import fpsa_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int DATA_W    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [DATA_W-1:0]   in_sample_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output fpsa_flags_t         job_flags_o,
  output logic [DATA_W:0]     job_pair0_o,
  output logic [DATA_W:0]     job_pair1_o,
  output logic [DATA_W-1:0]   job_mid_o,
  output logic [DATA_W-1:0]   job_s_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WX = (CW + 1 > CfgDataW) ? CW + 1 : CfgDataW;
  localparam int WidthReset = (MAX_WIDTH < DimReset) ? MAX_WIDTH : DimReset;

  // each entry: {row above, centre row}
  logic [2*DATA_W-1:0] line_mem [MAX_WIDTH];
  logic [2*DATA_W-1:0] rd_a_q, rd_b_q;

  logic [CW-1:0]   col_q, col_d, wlast_q, wlast_d;
  logic [RowW-1:0] row_q, row_d, hlast_q, hlast_d;
  logic [DATA_W-1:0] left_q;
  logic [CW-1:0]   col_nxt, addr_b, wclamp;
  logic [RowW-1:0] hclamp;
  logic [WX-1:0]   wx;
  logic            accept, last_col, last_row;
  logic [DATA_W-1:0] mid, up, right;

  assign in_ready_o  = job_ready_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  assign last_col = (col_q >= wlast_q);
  assign last_row = (row_q >= hlast_q);
  assign col_nxt  = last_col ? '0 : col_q + CW'(1);
  assign addr_b   = (col_nxt == CW'(MAX_WIDTH - 1)) ? '0 : col_nxt + CW'(1);

  assign mid   = rd_a_q[DATA_W-1:0];
  assign up    = rd_a_q[2*DATA_W-1:DATA_W];
  assign right = rd_b_q[DATA_W-1:0];

  // job towards the back part
  assign job_valid_o        = accept && (row_q != '0);
  assign job_flags_o.border = (row_q == RowW'(1)) || (col_q == '0) || last_col;
  assign job_flags_o.two    = last_row;
  assign job_flags_o.fend   = last_col;
  assign job_pair0_o        = (DATA_W+1)'(left_q) + (DATA_W+1)'(right);
  assign job_pair1_o        = (DATA_W+1)'(up) + (DATA_W+1)'(mid);
  assign job_mid_o          = mid;
  assign job_s_o            = in_sample_i;

  // dimension clamping, stored as last index
  always_comb begin
    wx = WX'(cfg_data_i);
    if (wx < WX'(MinDim)) begin
      wclamp = CW'(MinDim - 1);
    end else if (wx > WX'(MAX_WIDTH)) begin
      wclamp = CW'(MAX_WIDTH - 1);
    end else begin
      wclamp = CW'(wx - WX'(1));
    end
    if (cfg_data_i < CfgDataW'(MinDim)) begin
      hclamp = RowW'(MinDim - 1);
    end else if (cfg_data_i > CfgDataW'(HeightLimit)) begin
      hclamp = RowW'(HeightLimit - 1);
    end else begin
      hclamp = RowW'(cfg_data_i - CfgDataW'(1));
    end
  end

  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    if (cfg_valid_i) begin
      unique case (fpsa_reg_e'(cfg_index_i))
        REG_GRID_WIDTH:  wlast_d = wclamp;
        REG_GRID_HEIGHT: hlast_d = hclamp;
        default:         wlast_d = wlast_q;
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      col_d = col_nxt;
      if (last_col) begin
        row_d = last_row ? '0 : row_q + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      wlast_q <= CW'(WidthReset - 1);
      hlast_q <= RowW'(DimReset - 1);
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      wlast_q <= wlast_d;
      hlast_q <= hlast_d;
    end
  end

  // line store: write the current column, prefetch the next two
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[col_q] <= {mid, in_sample_i};
      rd_a_q          <= line_mem[col_nxt];
      rd_b_q          <= line_mem[addr_b];
      left_q          <= mid;
    end
  end

endmodule

[rtl/fpsa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_back: five-point sum, divide by five and result output
// Sum stage, one divider stage per byte, output register plus a slot for the
// second result of a last-row job.
// ----------------------------------------------------------------------------
module fpsa_back
  import fpsa_pkg::*;
#(
  parameter int DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  fpsa_flags_t       job_flags_i,
  input  logic [DATA_W:0]   job_pair0_i,
  input  logic [DATA_W:0]   job_pair1_i,
  input  logic [DATA_W-1:0] job_mid_i,
  input  logic [DATA_W-1:0] job_s_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_value_o,
  output logic              out_border_o,
  output logic              out_last_o
);

  localparam int NB = DATA_W + 3;
  localparam int NS = (NB + DivDigitW - 1) / DivDigitW;
  localparam int PW = NS * DivDigitW;

  logic [NS:0]       vld_q;
  logic [PW-1:0]     dvd_q [NS+1];
  logic [PW-1:0]     quo_q [NS+1];
  logic [2:0]        rem_q [NS+1];
  logic [DATA_W-1:0] mid_q [NS+1];
  logic [DATA_W-1:0] s_q   [NS+1];
  fpsa_flags_t       flg_q [NS+1];

  logic [NB-1:0]     sum;
  logic              advance, take, out_free;
  logic [DATA_W-1:0] res_value;

  logic              out_vld_q, out_vld_d, sec_vld_q, sec_vld_d;
  logic [DATA_W-1:0] out_val_q, out_val_d, sec_val_q, sec_val_d;
  logic              out_brd_q, out_brd_d, out_lst_q, out_lst_d;
  logic              sec_lst_q, sec_lst_d;

  assign out_free    = !out_vld_q || out_ready_i;
  assign take        = out_free && !sec_vld_q && vld_q[NS];
  assign advance     = !vld_q[NS] || take;
  assign job_ready_o = advance;

  assign sum = NB'(job_pair0_i) + NB'(job_pair1_i) + NB'(job_s_i) + NB'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[NS-1:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dvd_q[0] <= PW'(sum);
      quo_q[0] <= '0;
      rem_q[0] <= '0;
      mid_q[0] <= job_mid_i;
      s_q[0]   <= job_s_i;
      flg_q[0] <= job_flags_i;
    end
  end

  // one quotient byte per stage, most significant first
  for (genvar k = 1; k <= NS; k++) begin : g_div
    fpsa_digit_t dg;
    assign dg = div5_digit({rem_q[k-1], dvd_q[k-1][PW-1 -: DivDigitW]});
    always_ff @(posedge clk_i) begin
      if (advance) begin
        dvd_q[k] <= dvd_q[k-1] << DivDigitW;
        quo_q[k] <= {quo_q[k-1][PW-DivDigitW-1:0], dg.q};
        rem_q[k] <= dg.r;
        mid_q[k] <= mid_q[k-1];
        s_q[k]   <= s_q[k-1];
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  assign res_value = flg_q[NS].border ? mid_q[NS] : quo_q[NS][DATA_W-1:0];

  // output register and second-result slot
  always_comb begin
    out_vld_d = out_vld_q && !out_ready_i;
    out_val_d = out_val_q;
    out_brd_d = out_brd_q;
    out_lst_d = out_lst_q;
    sec_vld_d = sec_vld_q;
    sec_val_d = sec_val_q;
    sec_lst_d = sec_lst_q;
    if (out_free) begin
      if (sec_vld_q) begin
        out_vld_d = 1'b1;
        out_val_d = sec_val_q;
        out_brd_d = 1'b1;
        out_lst_d = sec_lst_q;
        sec_vld_d = 1'b0;
      end else if (vld_q[NS]) begin
        out_vld_d = 1'b1;
        out_val_d = res_value;
        out_brd_d = flg_q[NS].border;
        out_lst_d = 1'b0;
        sec_vld_d = flg_q[NS].two;
        sec_val_d = s_q[NS];
        sec_lst_d = flg_q[NS].fend;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sec_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      sec_vld_q <= sec_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q <= out_val_d;
    out_brd_q <= out_brd_d;
    out_lst_q <= out_lst_d;
    sec_val_q <= sec_val_d;
    sec_lst_q <= sec_lst_d;
  end

  assign out_valid_o  = out_vld_q;
  assign out_value_o  = out_val_q;
  assign out_border_o = out_brd_q;
  assign out_last_o   = out_lst_q;

endmodule

[tb/fpsa_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_result_checker: result prediction and comparison for the stencil block
// Watches the sample, result and configuration channels and keeps its own
// copy of the line stores, position and dimensions. Each accepted result is
// compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fpsa_result_checker
  import fpsa_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_valid_i,
  input  logic                    s_ready_i,
  input  logic [SampleFieldW-1:0] s_data_i,
  input  logic                    m_valid_i,
  input  logic                    m_ready_i,
  input  logic [SampleFieldW-1:0] m_data_i,
  input  logic                    m_user_i,
  input  logic                    m_last_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic                    cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  output int                      n_fail_o,
  output int                      n_pending_o,
  output logic                    frame_start_o
);

  typedef struct packed {
    logic [SampleFieldW-1:0] new_value;
    logic                    is_border;
    logic                    frame_end;
  } cell_result_t;

  cell_result_t            cells_due[$];
  logic [SampleFieldW-1:0] line_above [MAX_WIDTH];
  logic [SampleFieldW-1:0] line_centre[MAX_WIDTH];
  int unsigned             row_pos;
  int unsigned             col_pos;
  logic [CfgDataW-1:0]     width_reg;
  logic [CfgDataW-1:0]     height_reg;
  int                      fail_count;

  function automatic int unsigned dim_in_use(input logic [CfgDataW-1:0] raw,
                                             input int unsigned hi);
    if (raw < MinDim) return MinDim;
    if (raw > hi) return hi;
    return 32'(raw);
  endfunction

  task automatic flag_field(input string field, input logic [SampleFieldW-1:0] want,
                            input logic [SampleFieldW-1:0] got);
    fail_count++;
    $error("%s: expected %0h, got %0h", field, want, got);
  endtask

  // One accepted sample: emit the cell above (and the sample itself in the last row)
  task automatic stencil_update(input logic [SampleFieldW-1:0] s);
    int unsigned w, h, c, r;
    logic        last_col, last_row;
    logic [35:0] total;
    w = dim_in_use(width_reg, MAX_WIDTH);
    h = dim_in_use(height_reg, HeightLimit);
    c = col_pos % MAX_WIDTH;
    r = row_pos;
    last_col = (c >= w - 1);
    last_row = (r >= h - 1);
    if (r >= 1) begin
      if (r == 1 || c == 0 || last_col) begin
        cells_due.push_back('{new_value: line_centre[c], is_border: 1'b1, frame_end: 1'b0});
      end else begin
        total = 36'(line_centre[c]) + 36'(line_above[c - 1])
              + 36'(line_centre[(c + 1) % MAX_WIDTH]) + 36'(line_above[c]) + 36'(s);
        cells_due.push_back('{new_value: SampleFieldW'((total + 36'd2) / 36'd5),
                              is_border: 1'b0, frame_end: 1'b0});
      end
      if (last_row) cells_due.push_back('{new_value: s, is_border: 1'b1, frame_end: last_col});
    end
    line_above[c]  = line_centre[c];
    line_centre[c] = s;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((r + 1) & 32'h3FF);
    end else begin
      col_pos = (c + 1) & 32'h3FF;
    end
  endtask

  task automatic compare_result();
    cell_result_t want;
    if (cells_due.size() == 0) begin
      fail_count++;
      $error("new_value: nothing expected, got %0h", m_data_i);
    end else begin
      want = cells_due.pop_front();
      if (m_data_i !== want.new_value) flag_field("new_value", want.new_value, m_data_i);
      if (m_user_i !== want.is_border) begin
        flag_field("is_border", SampleFieldW'(want.is_border), SampleFieldW'(m_user_i));
      end
      if (m_last_i !== want.frame_end) begin
        flag_field("frame_end", SampleFieldW'(want.frame_end), SampleFieldW'(m_last_i));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_due.delete();
      row_pos       = 0;
      col_pos       = 0;
      width_reg     = CfgDataW'(DimReset);
      height_reg    = CfgDataW'(DimReset);
      fail_count    = 0;
      n_fail_o      <= 0;
      n_pending_o   <= 0;
      frame_start_o <= 1'b1;
    end else begin
      // results first: nothing can come out in the cycle its sample goes in
      if (m_valid_i && m_ready_i) compare_result();
      if (s_valid_i && s_ready_i) stencil_update(s_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_GRID_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
      end
      n_fail_o      <= fail_count;
      n_pending_o   <= cells_due.size();
      frame_start_o <= (row_pos == 0) && (col_pos == 0);
    end
  end

endmodule

[tb/five_point_stencil_average_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_point_stencil_average_tb: regression bench for the stencil averager
// Streams whole grids through the block under bursty input and a stalling
// output, changes dimensions between frames (and a few times mid-frame) and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module five_point_stencil_average_tb;
  import fpsa_pkg::*;

  localparam int MaxWidth      = 1024;
  localparam int SettleCycles  = 16;    // lets the divider pipeline run dry after the last result
  localparam int HoldOffCycles = 400;   // long output stall, fills the job queue
  localparam int RandomItems   = 1700;

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [SampleFieldW-1:0] s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [SampleFieldW-1:0] m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    m_axis_tlast;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic                    cfg_index_i   = 1'b0;
  logic [CfgDataW-1:0]     cfg_data_i    = '0;

  int   n_fail;
  int   n_pending;
  logic frame_start;

  // sender pacing and the one long receiver hold-off
  int   burst_left   = 1;
  int   n_sent       = 0;
  logic hold_off_req  = 1'b0;
  logic hold_off_done = 1'b0;

  five_point_stencil_average #(
    .MAX_WIDTH  (MaxWidth),
    .SAMPLE_BITS(SampleFieldW)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  fpsa_result_checker #(
    .MAX_WIDTH(MaxWidth)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_user_i     (m_axis_tuser),
    .m_last_i     (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .n_fail_o     (n_fail),
    .n_pending_o  (n_pending),
    .frame_start_o(frame_start)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Generous ceiling on the simulated time of the whole regression.
  initial begin : watchdog
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: stretches of always-ready, coin-flip, periodic, heavy and light
  // stalling, plus one long hold-off on request from the stimulus.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned mode, span, tick;
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(16, 160);
      for (tick = 0; tick < span; tick++) begin
        if (hold_off_req && !hold_off_done) begin
          m_axis_tready <= 1'b0;
          repeat (HoldOffCycles) @(posedge clk_i);
          hold_off_done <= 1'b1;
        end
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= (tick % 4) != 3;
          3:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sample side helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned dim_in_use(input logic [CfgDataW-1:0] raw,
                                             input int unsigned hi);
    if (raw < MinDim) return MinDim;
    if (raw > hi) return hi;
    return 32'(raw);
  endfunction

  // mix of rails, near-rails and full-range values
  function automatic logic [SampleFieldW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return SampleFieldW'($urandom_range(0, 15));
      3:       return 32'hFFFF_FFFF - SampleFieldW'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // one request on the sample channel; valid stays up on return
  task automatic push_sample(input logic [SampleFieldW-1:0] value);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // bursts of random length, random gaps; now and then a long unbroken run
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 24);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // stop sending until every predicted result has come back, then let the
  // divider pipeline run dry (row-zero samples leave nothing to wait on)
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (n_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input fpsa_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // a whole frame of random content; pause_at < 0 means no mid-frame pause
  task automatic run_frame(input logic [CfgDataW-1:0] w_raw,
                           input logic [CfgDataW-1:0] h_raw, input int pause_at);
    int cells;
    drain();
    write_reg(REG_GRID_WIDTH, w_raw);
    write_reg(REG_GRID_HEIGHT, h_raw);
    cells = dim_in_use(w_raw, MaxWidth) * dim_in_use(h_raw, HeightLimit);
    for (int i = 0; i < cells; i++) begin
      if (i == pause_at) drain();
      push_sample(pick_sample());
      pace();
    end
  endtask

  // single requests until the position wraps back to the frame origin
  task automatic finish_frame();
    while (!frame_start) begin
      push_sample(pick_sample());
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Two 3x3 frames: all rails (largest five-point sum, must come back as the
  // rail), then a cross of ones round a four that rounds 1.6 up to 2.
  logic [SampleFieldW-1:0] corner_case [18] = '{
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'd0, 32'd1, 32'd0,
    32'd1, 32'd4, 32'd1,
    32'd0, 32'd1, 32'd0
  };

  initial begin : stimulus
    int pick, spin;
    logic [CfgDataW-1:0] w, h;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: second frame writes below-range dimensions, clamped to 3x3
    for (int f = 0; f < 2; f++) begin
      drain();
      write_reg(REG_GRID_WIDTH,  (f == 0) ? CfgDataW'(3) : CfgDataW'(0));
      write_reg(REG_GRID_HEIGHT, (f == 0) ? CfgDataW'(3) : CfgDataW'(2));
      for (int i = 0; i < 9; i++) begin
        push_sample(corner_case[f * 9 + i]);
        pace();
      end
    end

    // over-range width: part of row 0, then a width below the column position
    // ends the row there. This also leaves the first 71 line-store entries written.
    drain();
    write_reg(REG_GRID_WIDTH, CfgDataW'(2047));
    write_reg(REG_GRID_HEIGHT, CfgDataW'(3));
    for (int i = 0; i < 70; i++) begin
      push_sample(pick_sample());
      pace();
    end
    drain();
    write_reg(REG_GRID_WIDTH, CfgDataW'(64));
    finish_frame();

    // over-range height: four rows in, then a height below the row position
    // turns the current row into the last one
    drain();
    write_reg(REG_GRID_WIDTH, CfgDataW'(3));
    write_reg(REG_GRID_HEIGHT, CfgDataW'(2047));
    for (int i = 0; i < 12; i++) begin
      push_sample(pick_sample());
      pace();
    end
    drain();
    write_reg(REG_GRID_HEIGHT, CfgDataW'(3));
    finish_frame();

    // dimensions changed mid-frame while the block is idle: after a paused frame,
    // start narrow, shrink the height onto the current row, then widen again
    // and run out to the end of the frame
    run_frame(CfgDataW'(10), CfgDataW'(8), 34);
    drain();
    write_reg(REG_GRID_WIDTH, CfgDataW'(4));
    for (int i = 0; i < 7; i++) begin
      push_sample(pick_sample());
      pace();
    end
    drain();
    write_reg(REG_GRID_HEIGHT, CfgDataW'(2));
    write_reg(REG_GRID_WIDTH, CfgDataW'(12));
    drain();
    finish_frame();

    // random frames; the first one runs into the long output hold-off
    drain();
    hold_off_req = 1'b1;
    run_frame(CfgDataW'(16), CfgDataW'(6), -1);
    while (n_sent < RandomItems) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        w = CfgDataW'($urandom_range(3, 12));
        h = CfgDataW'($urandom_range(3, 8));
      end else if (pick < 18) begin
        w = CfgDataW'($urandom_range(13, 64));
        h = CfgDataW'($urandom_range(3, 6));
      end else begin
        w = CfgDataW'($urandom_range(0, 2));
        h = CfgDataW'($urandom_range(0, 4));
      end
      run_frame(w, h, ($urandom_range(0, 7) == 0)
                      ? int'($urandom_range(1, dim_in_use(w, MaxWidth) * 2)) : -1);
    end

    // wind down: wait for the last results, bounded, then a quiet tail
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    for (spin = 0; spin < 20000 && n_pending != 0; spin++) @(posedge clk_i);
    repeat (2 * SettleCycles) @(posedge clk_i);

    if (n_fail == 0 && n_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
